// ===== rtl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared constants and types for the RGB to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned PIPE_DEPTH = 7;   // A, B, four divider stages, output
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS  = 4;   // quotient bits per divider stage
  localparam int unsigned QUO_W      = DIV_STAGES * DIV_STEPS;

  localparam logic [11:0] HUE_SIXTH  = 12'd3840;
  localparam logic [15:0] HUE_FULL   = 16'd23040;
  localparam logic [15:0] Q15_ONE    = 16'd32768;
  // ceil(2^23 / 255): y / 255 == (y * RECIP_255) >> 23 for y below 2^16
  localparam logic [15:0] RECIP_255  = 16'd32897;

  // which component holds the maximum
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0]       rem;    // partial remainder, below dvsr
    logic [QUO_W-1:0] low;    // numerator bits not yet shifted in
    logic [QUO_W-1:0] quo;    // quotient bits so far
    logic [7:0]       dvsr;
  } div_t;

  typedef struct packed {
    logic [1:0]  sel;
    logic        neg;         // hue difference below zero
    logic        undef;       // grey pixel
    logic        sat_zero;    // black pixel
    logic [15:0] val;
  } side_t;

endpackage

// ===== rtl/rgbhsv_if.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_if
// Valid/ready channels for RGB pixels in and HSV results out.
// ----------------------------------------------------------------------------
interface rgbhsv_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rgbhsv_hsv_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [15:0] brightness;
  logic        hue_undefined;

  modport source (output valid, hue, saturation, brightness, hue_undefined, input ready);
  modport sink   (input valid, hue, saturation, brightness, hue_undefined, output ready);
endinterface

// ===== rtl/rgbhsv_div_stage.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_div_stage
// One registered stage of the restoring divider: DIV_STEPS quotient bits.
// ----------------------------------------------------------------------------
module rgbhsv_div_stage (
  input  logic               clk,
  input  logic               en,
  input  rgbhsv_pkg::div_t   d_in,
  output rgbhsv_pkg::div_t   d_out
);
  import rgbhsv_pkg::*;

  div_t       d_next;
  logic [8:0] trial;

  always_comb begin
    d_next = d_in;
    trial  = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial      = {d_next.rem, d_next.low[QUO_W-1]};
      d_next.low = {d_next.low[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, d_next.dvsr}) begin
        d_next.rem = 8'(trial - {1'b0, d_next.dvsr});
        d_next.quo = {d_next.quo[QUO_W-2:0], 1'b1};
      end else begin
        d_next.rem = trial[7:0];
        d_next.quo = {d_next.quo[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// Path to hsv: stage A, stage B, four divider stages, output register.
// Throughput: one pixel per cycle unless hsv stalls; the saturation and hue
// divisions are restoring dividers over four stages of four quotient bits each.
// Each stage holds its item while the next one is full, so stalls drop nothing.
// Reset (rst, synchronous) clears the stage valid bits; payload is not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined 8-bit RGB to fixed-point HSV (hue deg*64, S and V in Q1.15).
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic          clk,
  input  logic          rst,
  rgbhsv_rgb_if.sink    rgb,
  rgbhsv_hsv_if.source  hsv
);
  import rgbhsv_pkg::*;

  logic [PIPE_DEPTH-1:0] v;
  logic [PIPE_DEPTH-1:0] rdy;

  // stage A
  logic [7:0] mx_next, mn_next, a_next;
  logic [1:0] sel_next;
  logic [8:0] diff_next;
  logic [7:0] a_mx, a_d, a_abs;
  logic [1:0] a_sel;
  logic       a_neg;

  // stage B
  logic [19:0] hue_num;
  logic [15:0] val_next;
  side_t       side_next;
  div_t        hue_init, sat_init;

  side_t side_q [1:DIV_STAGES+1];
  div_t  hue_div [1:DIV_STAGES+1];
  div_t  sat_div [1:DIV_STAGES+1];

  // output stage
  logic [15:0] hue_base;
  logic [16:0] hue_sum;
  logic [14:0] hue_next;

  logic [14:0] hue;
  logic [15:0] saturation;
  logic [15:0] brightness;
  logic        hue_undefined;

  // stall chain: a stage takes a new item when empty or when it moves on
  always_comb begin
    rdy[PIPE_DEPTH-1] = !v[PIPE_DEPTH-1] || hsv.ready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  assign rgb.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= rgb.valid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (rdy[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage A: max, min, sector and signed difference
  always_comb begin
    mx_next = rgb.red;
    mn_next = rgb.red;
    if (rgb.green > mx_next) mx_next = rgb.green;
    if (rgb.blue > mx_next)  mx_next = rgb.blue;
    if (rgb.green < mn_next) mn_next = rgb.green;
    if (rgb.blue < mn_next)  mn_next = rgb.blue;
    if (rgb.red == mx_next) begin
      sel_next  = SEL_RED;
      diff_next = {1'b0, rgb.green} - {1'b0, rgb.blue};
    end else if (rgb.green == mx_next) begin
      sel_next  = SEL_GREEN;
      diff_next = {1'b0, rgb.blue} - {1'b0, rgb.red};
    end else begin
      sel_next  = SEL_BLUE;
      diff_next = {1'b0, rgb.red} - {1'b0, rgb.green};
    end
    a_next = diff_next[8] ? 8'(~diff_next + 9'd1) : diff_next[7:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a_mx  <= mx_next;
      a_d   <= mx_next - mn_next;
      a_abs <= a_next;
      a_sel <= sel_next;
      a_neg <= diff_next[8];
    end
  end

  // stage B: numerators and brightness
  // negative hue: floor(-x/d) = -floor((x + d - 1)/d)
  always_comb begin
    hue_num = 20'(a_abs) * 20'(HUE_SIXTH);
    if (a_neg) begin
      hue_num = hue_num + 20'(a_d) - 20'd1;
    end
    // 32768*mx/255 = 128*mx + floor(128*mx/255)
    val_next = {1'b0, a_mx, 7'b0} + 16'((24'(a_mx) * 24'(RECIP_255)) >> 16);

    side_next.sel      = a_sel;
    side_next.neg      = a_neg;
    side_next.undef    = (a_d == 8'd0);
    side_next.sat_zero = (a_mx == 8'd0);
    side_next.val      = val_next;

    hue_init.rem  = 8'(hue_num >> QUO_W);
    hue_init.low  = hue_num[QUO_W-1:0];
    hue_init.quo  = '0;
    hue_init.dvsr = a_d;

    // numerator d * 2^15: top bits are d >> 1
    sat_init.rem  = {1'b0, a_d[7:1]};
    sat_init.low  = {a_d[0], 15'b0};
    sat_init.quo  = '0;
    sat_init.dvsr = a_mx;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      side_q[1]  <= side_next;
      hue_div[1] <= hue_init;
      sat_div[1] <= sat_init;
    end
  end

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
    rgbhsv_div_stage u_hue_div (
      .clk   (clk),
      .en    (rdy[s+1]),
      .d_in  (hue_div[s]),
      .d_out (hue_div[s+1])
    );

    rgbhsv_div_stage u_sat_div (
      .clk   (clk),
      .en    (rdy[s+1]),
      .d_in  (sat_div[s]),
      .d_out (sat_div[s+1])
    );

    always_ff @(posedge clk) begin
      if (rdy[s+1]) begin
        side_q[s+1] <= side_q[s];
      end
    end
  end

  // output stage: sector offset, sign and wrap
  always_comb begin
    case (side_q[DIV_STAGES+1].sel)
      SEL_RED:   hue_base = 16'd0;
      SEL_GREEN: hue_base = 16'(HUE_SIXTH) << 1;
      SEL_BLUE:  hue_base = 16'(HUE_SIXTH) << 2;
      default:   hue_base = 16'd0;
    endcase
    if (side_q[DIV_STAGES+1].neg) begin
      hue_sum = {1'b0, hue_base} - {1'b0, hue_div[DIV_STAGES+1].quo};
    end else begin
      hue_sum = {1'b0, hue_base} + {1'b0, hue_div[DIV_STAGES+1].quo};
    end
    if (hue_sum[16]) begin
      hue_sum = hue_sum + {1'b0, HUE_FULL};
    end
    hue_next = side_q[DIV_STAGES+1].undef ? 15'd0 : hue_sum[14:0];
  end

  always_ff @(posedge clk) begin
    if (rdy[PIPE_DEPTH-1]) begin
      hue           <= hue_next;
      saturation    <= side_q[DIV_STAGES+1].sat_zero ? 16'd0 : sat_div[DIV_STAGES+1].quo;
      brightness    <= side_q[DIV_STAGES+1].val;
      hue_undefined <= side_q[DIV_STAGES+1].undef;
    end
  end

  assign hsv.valid         = v[PIPE_DEPTH-1];
  assign hsv.hue           = hue;
  assign hsv.saturation    = saturation;
  assign hsv.brightness    = brightness;
  assign hsv.hue_undefined = hue_undefined;

  a_undef_hue_zero: assert property (@(posedge clk) disable iff (rst)
    hsv.valid && hsv.hue_undefined |-> hsv.hue == 15'd0)
    else $error("hue not zero on grey pixel");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> hsv.hue < HUE_FULL[14:0])
    else $error("hue out of range");

  a_q15_range: assert property (@(posedge clk) disable iff (rst)
    hsv.valid |-> (hsv.saturation <= Q15_ONE) && (hsv.brightness <= Q15_ONE))
    else $error("saturation or brightness above 1.0");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v[PIPE_DEPTH-2] && !rdy[PIPE_DEPTH-1] |=> v[PIPE_DEPTH-2])
    else $error("item lost in last divider stage during stall");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !hsv.valid)
    else $error("result valid right after reset");

endmodule
